// ===== src/sfp_pkg.sv =====
// Shared constants, tables and small arithmetic helpers for the four-pillars block.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int unsigned YearBase = 1900;
  localparam int unsigned YearLast = 2099;
  localparam int unsigned RomRows  = 67;
  localparam int unsigned RowW     = $clog2(RomRows);

  // Spring Festival offset, three years per word, first year in the top byte.
  localparam logic [23:0] SF_ROM [RomRows] = '{
    24'hBF5348, 24'hBD5044, 24'hB94D42, 24'hB64ABE, 24'h5246BA, 24'h4E4337, 24'h4BC154,
    24'h48BC50, 24'h45B84D, 24'h42B74A, 24'h3E5146, 24'hBA4E44, 24'h384BBF, 24'h53483B,
    24'h4F45B9, 24'h4D42B6, 24'h4ABD51, 24'h46BB4E, 24'h43B84C, 24'h3F5248, 24'h3C4F45,
    24'h394D42, 24'h3549BE, 24'h5146BB, 24'h4F43B7, 24'h4BBF52, 24'h473C50, 24'h45B94D,
    24'hC25449, 24'h3D5146, 24'hBB4F44, 24'h374ABF, 24'h5347BC, 24'h5045B8, 24'h4C41B6,
    24'h49BD52, 24'h47BA4E, 24'h43374A, 24'hBF5348, 24'hBC5045, 24'hB94C41, 24'hB64A3D,
    24'h51463A, 24'h4D4337, 24'h4BBF53, 24'h48BC4F, 24'h44384C, 24'h41B64A, 24'hBE5146,
    24'hBA4E42, 24'h374BC1, 24'h53483C, 24'h4F4438, 24'h4C4235, 24'h49BD51, 24'h45BA4E,
    24'h43B74B, 24'hBF5347, 24'h3B4F45, 24'h384C42, 24'hB649BD, 24'h5146BA, 24'h4E4338,
    24'h4A3E52, 24'h473B4F, 24'h45B94C, 24'h41B549
  };

  // Day-cycle index of the last day of February, three years per word.
  localparam logic [23:0] FE_ROM [RomRows] = '{
    24'h090e13, 24'h181e23, 24'h282d33, 24'h380106, 24'h0c1116, 24'h1b2126, 24'h2b3036,
    24'h3b0409, 24'h0f1419, 24'h1e2429, 24'h2e3339, 24'h02070c, 24'h12171c, 24'h21272c,
    24'h313600, 24'h050a0f, 24'h151a1f, 24'h242a2f, 24'h343903, 24'h080d12, 24'h181d22,
    24'h272d32, 24'h370006, 24'h0b1015, 24'h1b2025, 24'h2a3035, 24'h3a0309, 24'h0e1318,
    24'h1e2328, 24'h2d3338, 24'h01060c, 24'h11161b, 24'h21262b, 24'h30363b, 24'h04090f,
    24'h14191e, 24'h24292e, 24'h333902, 24'h070c12, 24'h171c21, 24'h272c31, 24'h360005,
    24'h0a0f15, 24'h1a1f24, 24'h2a2f34, 24'h390308, 24'h0d1218, 24'h1d2227, 24'h2d3237,
    24'h00060b, 24'h10151b, 24'h20252a, 24'h30353a, 24'h03090e, 24'h13181e, 24'h23282d,
    24'h333801, 24'h060c11, 24'h161b21, 24'h262b30, 24'h363b04, 24'h090f14, 24'h191e24,
    24'h292e33, 24'h390207, 24'h0c1217, 24'h1c2126
  };

  localparam logic [8:0] MONTH_START [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273, 9'd304,
    9'd334, 9'd365
  };

  localparam logic [5:0] MONTH_DAY_OFS [12] = '{
    6'd6, 6'd37, 6'd0, 6'd31, 6'd1, 6'd32, 6'd2, 6'd33, 6'd4, 6'd34, 6'd5, 6'd35
  };

  // Month number 1..12; anything else reads as month 1.
  function automatic logic [3:0] month_idx(input logic [3:0] m);
    logic [3:0] r;
    r = (m >= 4'd1 && m <= 4'd12) ? m - 4'd1 : 4'd0;
    return r;
  endfunction

  // Byte of a three-years-per-word table; row clamps to the last entry.
  function automatic logic [7:0] rom_byte(input logic [23:0] rom [RomRows],
                                          input logic [RowW-1:0] row,
                                          input logic [1:0] sel);
    logic [23:0] w;
    logic [7:0]  b;
    w = (row > RowW'(RomRows - 1)) ? rom[RomRows-1] : rom[row];
    case (sel)
      2'd0:    b = w[23:16];
      2'd1:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  // x / 3 by reciprocal; exact for any 8-bit x.
  function automatic logic [RowW+1:0] div3(input logic [7:0] x);
    logic [15:0] p;
    logic [6:0]  q;
    logic [8:0]  rem;
    p   = x * 16'd171;
    q   = p[15:9];
    rem = {1'b0, x} - 9'(q * 3);
    return {q[RowW-1:0], rem[1:0]};
  endfunction

  function automatic logic [3:0] mod10(input logic [7:0] x);
    logic [17:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = x * 18'd205;
    q = p[15:11];
    r = x - 8'(q * 10);
    return r[3:0];
  endfunction

  function automatic logic [3:0] mod12(input logic [7:0] x);
    logic [17:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = x * 18'd171;
    q = p[15:11];
    r = x - 8'(q * 12);
    return r[3:0];
  endfunction

  // Fold a value below 30 into 0..9.
  function automatic logic [3:0] fold10(input logic [4:0] x);
    logic [4:0] r;
    r = (x >= 5'd20) ? x - 5'd20 : (x >= 5'd10) ? x - 5'd10 : x;
    return r[3:0];
  endfunction

endpackage

// ===== src/sfp_if.sv =====
// Valid/ready channel interfaces for the date request and the pillar result.
// Depends on nothing.
`timescale 1ns / 1ps

interface sfp_req_if;
  logic        valid;
  logic        ready;
  logic [11:0] greg_year;
  logic [3:0]  greg_month;
  logic [4:0]  greg_day;
  logic [4:0]  clock_hour;
  logic [4:0]  jie_term_day;

  modport source (output valid, greg_year, greg_month, greg_day, clock_hour, jie_term_day,
                  input ready);
  modport sink (input valid, greg_year, greg_month, greg_day, clock_hour, jie_term_day,
                output ready);
endinterface

interface sfp_rsp_if;
  logic       valid;
  logic       ready;
  logic       input_error;
  logic [3:0] year_stem;
  logic [3:0] year_branch;
  logic [3:0] month_stem;
  logic [3:0] month_branch;
  logic [3:0] day_stem;
  logic [3:0] day_branch;
  logic [3:0] hour_stem;
  logic [3:0] hour_branch;

  modport source (output valid, input_error, year_stem, year_branch, month_stem,
                  month_branch, day_stem, day_branch, hour_stem, hour_branch,
                  input ready);
  modport sink (input valid, input_error, year_stem, year_branch, month_stem,
                month_branch, day_stem, day_branch, hour_stem, hour_branch,
                output ready);
endinterface

// ===== src/sexagenary_four_pillars.sv =====
// Four pillars of the sexagenary cycle: three-stage pipeline from date to stem/branch pairs.
// Depends on sfp_pkg and the channel interfaces in sfp_if.sv.
//
// One date and hour (March 1900 to 2099) goes in per transaction, with the day of that
// month's first solar term, and one result comes out: stem and branch of the year, solar
// month, day and double hour, or input_error with all other fields zero. The block takes a
// new transaction every cycle while no stall has backed up to the input; each result passes
// through the three pipeline registers (check and table address, table lookup and month
// pillar, modulo reduction) in turn. A stall on the result side backs up stage by stage,
// so empty stages keep accepting while a finished result waits.
`timescale 1ns / 1ps

module sexagenary_four_pillars
  import sfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  sfp_req_if.sink   req,
  sfp_rsp_if.source rsp
);

  typedef struct packed {
    logic            err;
    logic [RowW-1:0] sf_row;
    logic [1:0]      sf_sel;
    logic [RowW-1:0] fe_row;
    logic [1:0]      fe_sel;
    logic [8:0]      doy;
    logic [7:0]      k1;      // year - 1899
    logic [7:0]      ks;      // solar year - 1899
    logic [3:0]      midx;
    logic [4:0]      day;
    logic [4:0]      hour;
    logic            before_jie;
  } s1_t;

  typedef struct packed {
    logic       err;
    logic [7:0] kl1;          // lunar year - 1899
    logic [3:0] mstem;
    logic [3:0] mbranch;
    logic [5:0] gd;
    logic [4:0] hour;
  } s2_t;

  typedef struct packed {
    logic       err;
    logic [3:0] ystem;
    logic [3:0] ybranch;
    logic [3:0] mstem;
    logic [3:0] mbranch;
    logic [3:0] dstem;
    logic [3:0] dbranch;
    logic [3:0] hstem;
    logic [3:0] hbranch;
  } s3_t;

  logic s1_valid, s2_valid, s3_valid;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;
  logic adv1, adv2, adv3;

  assign adv3      = !s3_valid || rsp.ready;
  assign adv2      = !s2_valid || adv3;
  assign adv1      = !s1_valid || adv2;
  assign req.ready = adv1;

  // Stage 1: range checks, day of year, table addresses.
  always_comb begin
    logic [11:0] yoff;
    logic [11:0] y1;
    logic        leap;
    logic [3:0]  m;
    logic [8:0]  mlen;
    logic        sy_prev;
    logic [7:0]  k;
    logic [7:0]  k_fe;
    logic [8:0]  d3_sf;
    logic [8:0]  d3_fe;
    yoff    = req.greg_year - 12'(YearBase);
    y1      = req.greg_year - 12'(YearBase - 1);
    m       = req.greg_month;
    leap    = (req.greg_year[1:0] == 2'b00) && (req.greg_year != 12'(YearBase));
    s1_next.midx = month_idx(m);
    mlen    = MONTH_START[s1_next.midx + 4'd1] - MONTH_START[s1_next.midx]
              + 9'((m == 4'd2) && leap);
    s1_next.err = (req.greg_year < 12'(YearBase)) || (req.greg_year > 12'(YearLast))
                || (m < 4'd1) || (m > 4'd12) || (req.clock_hour > 5'd23)
                || (req.greg_day == 5'd0) || (req.jie_term_day == 5'd0)
                || ((req.greg_year == 12'(YearBase)) && (m <= 4'd2))
                || (9'(req.greg_day) > mlen);
    s1_next.doy = MONTH_START[s1_next.midx] + 9'(req.greg_day) + 9'((m > 4'd2) && leap);
    s1_next.before_jie = req.greg_day < req.jie_term_day;
    sy_prev = (m == 4'd1) || ((m == 4'd2) && s1_next.before_jie);
    s1_next.k1 = y1[7:0];
    s1_next.ks = y1[7:0] - 8'(sy_prev);
    k       = yoff[7:0];
    k_fe    = k - 8'(m <= 4'd2);
    d3_sf   = div3(k);
    d3_fe   = div3(k_fe);
    s1_next.sf_row = d3_sf[RowW+1:2];
    s1_next.sf_sel = d3_sf[1:0];
    s1_next.fe_row = d3_fe[RowW+1:2];
    s1_next.fe_sel = d3_fe[1:0];
    s1_next.day  = req.greg_day;
    s1_next.hour = req.clock_hour;
  end

  // Stage 2: table lookups, lunar year, month pillar, day cycle.
  always_comb begin
    logic [7:0] sfb;
    logic [7:0] feb;
    logic [5:0] fest;
    logic [4:0] mm;
    logic [3:0] mst;
    logic [3:0] s;
    logic [3:0] s5;
    logic [8:0] gd_raw;
    sfb  = rom_byte(SF_ROM, s1.sf_row, s1.sf_sel);
    feb  = rom_byte(FE_ROM, s1.fe_row, s1.fe_sel);
    fest = 6'(sfb[4:0]) + ((sfb[6:5] == 2'd1) ? 6'd0 : 6'd31);
    s2_next.err = s1.err;
    s2_next.kl1 = s1.k1 - 8'(s1.doy < 9'(fest));
    // month number is midx+1; solar month = ((m + 9 or 10) mod 12) + 1
    mm   = 5'(s1.midx) + (s1.before_jie ? 5'd10 : 5'd11);
    mm   = (mm >= 5'd12) ? mm - 5'd12 : mm;
    mst  = mm[3:0] + 4'd1;
    s    = mod10(s1.ks + 8'd5);
    s5   = (s >= 4'd5) ? s - 4'd5 : s;
    s2_next.mstem   = fold10(5'(mst) + 5'd1 + 5'({s5, 1'b0}));
    s2_next.mbranch = (mst >= 4'd11) ? mst - 4'd11 : mst + 4'd1;
    gd_raw = 9'(feb) + 9'(MONTH_DAY_OFS[s1.midx]) + 9'(s1.day);
    gd_raw = (gd_raw >= 9'd120) ? gd_raw - 9'd120 : (gd_raw >= 9'd60) ? gd_raw - 9'd60 : gd_raw;
    s2_next.gd   = gd_raw[5:0];
    s2_next.hour = s1.hour;
  end

  // Stage 3: modulo reduction into stems and branches; zero on error.
  always_comb begin
    logic       h23;
    logic [3:0] gh;
    logic [3:0] ds;
    logic [3:0] ds5;
    logic [4:0] hp1;
    h23 = (s2.hour == 5'd23);
    hp1 = s2.hour + 5'd1;
    gh  = ((s2.hour == 5'd0) || h23) ? 4'd0 : hp1[4:1];
    ds  = mod10(8'(s2.gd) + 8'd9 + 8'(h23));
    ds5 = (ds >= 4'd5) ? ds - 4'd5 : ds;
    s3_next.err     = s2.err;
    s3_next.ystem   = mod10(s2.kl1 + 8'd5);
    s3_next.ybranch = mod12(s2.kl1 + 8'd11);
    s3_next.mstem   = s2.mstem;
    s3_next.mbranch = s2.mbranch;
    s3_next.dstem   = mod10(8'(s2.gd) + 8'd9);
    s3_next.dbranch = mod12(8'(s2.gd) + 8'd11);
    s3_next.hstem   = fold10(5'(gh) + 5'({ds5, 1'b0}));
    s3_next.hbranch = gh;
    if (s2.err) begin
      s3_next = '0;
      s3_next.err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= req.valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1 <= s1_next;
    if (adv2) s2 <= s2_next;
    if (adv3) s3 <= s3_next;
  end

  assign rsp.valid        = s3_valid;
  assign rsp.input_error  = s3.err;
  assign rsp.year_stem    = s3.ystem;
  assign rsp.year_branch  = s3.ybranch;
  assign rsp.month_stem   = s3.mstem;
  assign rsp.month_branch = s3.mbranch;
  assign rsp.day_stem     = s3.dstem;
  assign rsp.day_branch   = s3.dbranch;
  assign rsp.hour_stem    = s3.hstem;
  assign rsp.hour_branch  = s3.hbranch;

endmodule

// ===== src/sfp_checker.sv =====
// Port-level checks for the four-pillars block, attached to the top level by bind.
// Depends on sexagenary_four_pillars and its channel interfaces.
`timescale 1ns / 1ps

module sfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_error,
  input logic [3:0] ys,
  input logic [3:0] yb,
  input logic [3:0] ms,
  input logic [3:0] mb,
  input logic [3:0] dst,
  input logic [3:0] db,
  input logic [3:0] hs,
  input logic [3:0] hb
);

  // An error transaction carries nothing but the flag.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |->
      ys == 4'd0 && yb == 4'd0 && ms == 4'd0 && mb == 4'd0 &&
      dst == 4'd0 && db == 4'd0 && hs == 4'd0 && hb == 4'd0)
    else $error("error result with nonzero pillar fields");

  // Stems stay below 10, branches below 12.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ys <= 4'd9 && ms <= 4'd9 && dst <= 4'd9 && hs <= 4'd9 &&
      yb <= 4'd11 && mb <= 4'd11 && db <= 4'd11 && hb <= 4'd11)
    else $error("stem or branch out of range");

  // A draining output lets the whole pipeline advance.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_error) && $stable(hb) && $stable(db))
    else $error("stalled result changed");

endmodule

bind sexagenary_four_pillars sfp_checker u_sfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_error (rsp.input_error),
  .ys        (rsp.year_stem),
  .yb        (rsp.year_branch),
  .ms        (rsp.month_stem),
  .mb        (rsp.month_branch),
  .dst       (rsp.day_stem),
  .db        (rsp.day_branch),
  .hs        (rsp.hour_stem),
  .hb        (rsp.hour_branch)
);
